// ===== rtl/chained_hash_key_value_table_defines.svh =====
// ----------------------------------------------------------------------------
// Chained hash key-value table assertion macros
// Shared concurrent assertion forms for the table's controller and datapath.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH
`define CHAINED_HASH_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define CHKV_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHKV_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/chkv_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table package
// Field widths, request codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package chkv_pkg;

	localparam int OP_W        = 2;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int NODE_W      = 7;
	localparam int CNT_W       = 7;
	localparam int HASH_DIGIT  = 4;
	localparam int HASH_DIGITS = KEY_W / HASH_DIGIT;
	localparam int HASH_STEPS  = 3;
	localparam int HCNT_W      = $clog2(HASH_STEPS);

	localparam logic [NODE_W-1:0] CHAIN_END = 7'd127;

	localparam logic [OP_W-1:0] OP_PUT  = 2'd0;
	localparam logic [OP_W-1:0] OP_GET  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL  = 2'd2;
	localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

	typedef struct packed {
		logic clear;
		logic load;
		logic hash;
		logic fix;
		logic head;
		logic walk;
		logic act;
		logic link;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic op_ok;
		logic hash_last;
		logic walk_stop;
		logic tail_link;
	} sts_t;

endpackage

// ===== rtl/chkv_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one put, get or remove word.
// ----------------------------------------------------------------------------
interface chkv_req_if;
	import chkv_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [KEY_W-1:0] key;
	logic [VAL_W-1:0]        value;

	modport source (output valid, output op, output key, output value, input ready);
	modport sink   (input valid, input op, input key, input value, output ready);
endinterface

// ===== rtl/chkv_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface chkv_rsp_if;
	import chkv_pkg::*;

	logic             valid;
	logic             ready;
	logic             found;
	logic [VAL_W-1:0] read_value;
	logic             table_full;
	logic [CNT_W-1:0] entry_total;

	modport source (output valid, output found, output read_value, output table_full,
		output entry_total, input ready);
	modport sink   (input valid, input found, input read_value, input table_full,
		input entry_total, output ready);
endinterface

// ===== rtl/chkv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module chkv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/chkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// Chained hash table controller
// Sequences clear, hash, chain walk, update and result hand-off.
// ----------------------------------------------------------------------------
`include "chained_hash_key_value_table_defines.svh"

module chkv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  chkv_pkg::sts_t sts,
	output chkv_pkg::cmd_t cmd
);
	import chkv_pkg::*;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_HASH  = 4'd2;
	localparam logic [3:0] S_FIX   = 4'd3;
	localparam logic [3:0] S_HEAD  = 4'd4;
	localparam logic [3:0] S_WALK  = 4'd5;
	localparam logic [3:0] S_ACT   = 4'd6;
	localparam logic [3:0] S_LINK  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.op_ok ? S_HASH : S_DONE;
				end
			end
			S_HASH: begin
				cmd.hash = 1'b1;
				if (sts.hash_last) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head = 1'b1;
				state_d  = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_stop) begin
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				cmd.act = 1'b1;
				state_d = sts.tail_link ? S_LINK : S_DONE;
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.done) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CHKV_ASSERT_IMP(a_out_from_done, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside done")
	`CHKV_ASSERT_IMP(a_link_after_act, clk, arst_n, state_q == S_LINK, $past(state_q) == S_ACT, "tail link without append")
endmodule

// ===== rtl/chkv_dp.sv =====
// ----------------------------------------------------------------------------
// Chained hash table datapath
// Bucket remainder, chain walk, node pool memories and result register.
// ----------------------------------------------------------------------------
`include "chained_hash_key_value_table_defines.svh"

module chkv_dp #(
	parameter int NUM_BUCKETS = 16,
	parameter int POOL_SIZE   = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chkv_pkg::cmd_t                cmd,
	output chkv_pkg::sts_t                sts,
	input  logic [chkv_pkg::OP_W-1:0]     req_op,
	input  logic signed [chkv_pkg::KEY_W-1:0] req_key,
	input  logic [chkv_pkg::VAL_W-1:0]    req_value,
	output logic                          found,
	output logic [chkv_pkg::VAL_W-1:0]    read_value,
	output logic                          table_full,
	output logic [chkv_pkg::CNT_W-1:0]    entry_total
);
	import chkv_pkg::*;

	localparam int BKT_W  = $clog2(NUM_BUCKETS);
	localparam int NA_W   = $clog2(POOL_SIZE);
	localparam int SUM_W  = BKT_W + HASH_DIGIT + $clog2(HASH_DIGITS);
	localparam int SHIFT  = SUM_W + BKT_W;
	localparam int MUL_W  = SUM_W + 2;
	localparam int PROD_W = SUM_W + MUL_W;

	// residue of each key nibble weight, 16**i mod NUM_BUCKETS
	function automatic logic [HASH_DIGITS*BKT_W-1:0] nib_table();
		logic [HASH_DIGITS*BKT_W-1:0] t;
		longint                       p;
		t = '0;
		p = 1;
		for (int i = 0; i < HASH_DIGITS; i++) begin
			t[i*BKT_W +: BKT_W] = BKT_W'(p);
			p = (p << HASH_DIGIT) % NUM_BUCKETS;
		end
		return t;
	endfunction

	localparam logic [HASH_DIGITS*BKT_W-1:0] NIB_RES = nib_table();
	localparam logic [MUL_W-1:0]  RECIP  = MUL_W'(((64'd1 << SHIFT) + 64'(NUM_BUCKETS)
		- 64'd1) / 64'(NUM_BUCKETS));
	localparam logic [32:0]       TWO_32 = 33'h1_0000_0000;
	localparam logic [BKT_W:0]    NB     = (BKT_W+1)'(NUM_BUCKETS);
	localparam logic [BKT_W-1:0]  WRAP   = BKT_W'(TWO_32 % NUM_BUCKETS);
	localparam logic [NODE_W-1:0] POOL_N = NODE_W'(POOL_SIZE);

	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [SUM_W-1:0]  rsum_q, rsum_nx, quo_q, back;
	logic [PROD_W-1:0] prod;
	logic [HCNT_W-1:0] hcnt_q;
	logic [BKT_W-1:0]  rem_q, rem_nx, bkt_fix, bucket_q, clr_q;
	logic [BKT_W:0]    fix_t;
	logic [NODE_W-1:0] cur_q, prev_q, nlink_q, free_q, free_nx;
	logic [CNT_W-1:0]  steps_q, count_q;
	logic              hit_q, free_ok_q, free_hit, full_q;
	logic [VAL_W-1:0]  rd_q;
	logic [POOL_SIZE-1:0] in_use_q;

	logic              cur_valid, prev_ok, at_limit, hit_now;

	logic              head_we, key_we, val_we, link_we;
	logic [BKT_W-1:0]  head_waddr;
	logic [NODE_W-1:0] head_wdata, head_rd, link_wdata, link_rd;
	logic [NA_W-1:0]   val_waddr, link_waddr, node_raddr;
	logic [KEY_W-1:0]  key_rd;
	logic [VAL_W-1:0]  val_rd;

	always_comb begin
		rsum_nx = '0;
		for (int i = 0; i < HASH_DIGITS; i++) begin
			rsum_nx = rsum_nx + SUM_W'(key_q[i*HASH_DIGIT +: HASH_DIGIT])
				* SUM_W'(NIB_RES[i*BKT_W +: BKT_W]);
		end
	end

	always_comb begin
		prod   = PROD_W'(rsum_q) * PROD_W'(RECIP);
		back   = quo_q * SUM_W'(NUM_BUCKETS);
		rem_nx = BKT_W'(rsum_q - back);
	end

	always_comb begin
		fix_t   = {1'b0, rem_q} + NB - {1'b0, WRAP};
		bkt_fix = rem_q;
		if (key_q[KEY_W-1]) begin
			bkt_fix = (rem_q >= WRAP) ? (rem_q - WRAP) : fix_t[BKT_W-1:0];
		end
	end

	always_comb begin
		free_nx  = CHAIN_END;
		free_hit = 1'b0;
		for (int i = POOL_SIZE - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_nx  = NODE_W'(i);
				free_hit = 1'b1;
			end
		end
	end

	assign cur_valid = (cur_q < POOL_N);
	assign prev_ok   = (prev_q < POOL_N);
	assign at_limit  = (steps_q == CNT_W'(POOL_SIZE));
	assign hit_now   = cur_valid && !at_limit && (key_rd == key_q);

	assign sts.clear_done = (clr_q == BKT_W'(NUM_BUCKETS - 1));
	assign sts.op_ok      = (req_op != OP_RSVD);
	assign sts.hash_last  = (hcnt_q == HCNT_W'(HASH_STEPS - 1));
	assign sts.walk_stop  = !cur_valid || at_limit || hit_now;
	assign sts.tail_link  = (op_q == OP_PUT) && !hit_q && free_ok_q && prev_ok;

	assign node_raddr = cmd.head ? head_rd[NA_W-1:0] : link_rd[NA_W-1:0];

	always_comb begin
		head_we    = 1'b0;
		head_waddr = bucket_q;
		head_wdata = free_q;
		key_we     = 1'b0;
		val_we     = 1'b0;
		val_waddr  = free_q[NA_W-1:0];
		link_we    = 1'b0;
		link_waddr = free_q[NA_W-1:0];
		link_wdata = CHAIN_END;
		if (cmd.clear) begin
			head_we    = 1'b1;
			head_waddr = clr_q;
			head_wdata = CHAIN_END;
		end
		if (cmd.act && op_q == OP_PUT) begin
			if (hit_q) begin
				val_we    = 1'b1;
				val_waddr = cur_q[NA_W-1:0];
			end else if (free_ok_q) begin
				key_we  = 1'b1;
				val_we  = 1'b1;
				link_we = 1'b1;
				head_we = !prev_ok;
			end
		end
		if (cmd.act && op_q == OP_DEL && hit_q) begin
			if (prev_ok) begin
				link_we    = 1'b1;
				link_waddr = prev_q[NA_W-1:0];
				link_wdata = nlink_q;
			end else begin
				head_we    = 1'b1;
				head_wdata = nlink_q;
			end
		end
		if (cmd.link) begin
			link_we    = 1'b1;
			link_waddr = prev_q[NA_W-1:0];
			link_wdata = free_q;
		end
	end

	chkv_ram #(.WIDTH(NODE_W), .DEPTH(NUM_BUCKETS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (head_wdata),
		.raddr (bkt_fix),
		.rdata (head_rd)
	);

	chkv_ram #(.WIDTH(KEY_W), .DEPTH(POOL_SIZE)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (free_q[NA_W-1:0]),
		.wdata (key_q),
		.raddr (node_raddr),
		.rdata (key_rd)
	);

	chkv_ram #(.WIDTH(VAL_W), .DEPTH(POOL_SIZE)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (value_q),
		.raddr (node_raddr),
		.rdata (val_rd)
	);

	chkv_ram #(.WIDTH(NODE_W), .DEPTH(POOL_SIZE)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (node_raddr),
		.rdata (link_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			in_use_q <= '0;
			count_q  <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (cmd.act && op_q == OP_PUT && !hit_q && free_ok_q) begin
				in_use_q[free_q[NA_W-1:0]] <= 1'b1;
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.act && op_q == OP_DEL && hit_q) begin
				in_use_q[cur_q[NA_W-1:0]] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= req_op;
			key_q     <= req_key;
			value_q   <= req_value;
			hcnt_q    <= '0;
			rem_q     <= '0;
			hit_q     <= 1'b0;
			full_q    <= 1'b0;
			free_q    <= free_nx;
			free_ok_q <= free_hit;
		end
		if (cmd.hash) begin
			rsum_q <= rsum_nx;
			quo_q  <= SUM_W'(prod >> SHIFT);
			rem_q  <= rem_nx;
			hcnt_q <= hcnt_q + HCNT_W'(1);
		end
		if (cmd.fix) begin
			bucket_q <= bkt_fix;
		end
		if (cmd.head) begin
			cur_q   <= head_rd;
			prev_q  <= CHAIN_END;
			steps_q <= '0;
		end
		if (cmd.walk) begin
			if (hit_now) begin
				hit_q   <= 1'b1;
				rd_q    <= val_rd;
				nlink_q <= link_rd;
			end else if (!sts.walk_stop) begin
				prev_q  <= cur_q;
				cur_q   <= link_rd;
				steps_q <= steps_q + CNT_W'(1);
			end
		end
		if (cmd.act && op_q == OP_PUT && !hit_q && !free_ok_q) begin
			full_q <= 1'b1;
		end
		if (cmd.done) begin
			found       <= hit_q;
			read_value  <= (op_q == OP_GET && hit_q) ? rd_q : '0;
			table_full  <= full_q;
			entry_total <= count_q;
		end
	end

	`CHKV_ASSERT_IMP(a_count_match, clk, arst_n, 1'b1, count_q == CNT_W'($countones(in_use_q)), "entry count differs from used nodes")
	`CHKV_ASSERT_IMP(a_walk_bound, clk, arst_n, cmd.walk, steps_q <= CNT_W'(POOL_SIZE), "chain walk past pool size")
	`CHKV_ASSERT_NXT(a_remove_frees, clk, arst_n, cmd.act && op_q == OP_DEL && hit_q, !in_use_q[$past(cur_q[NA_W-1:0])], "removed node still in use")
endmodule

// ===== rtl/chained_hash_key_value_table.sv =====
// ----------------------------------------------------------------------------
// Chained hash key-value table
// Put, get and remove on signed 32-bit keys, chained per bucket in a node pool.
// ----------------------------------------------------------------------------
//   channel  dir  word
//   req      in   op, key, value
//   rsp      out  found, read_value, table_full, entry_total
//
// One request at a time: load, bucket remainder, sign fix, head read, chain
// walk over one node per step up to a match, the chain end or the pool-size
// limit, update and result hand-off, plus a tail link step when a new node
// is linked behind an existing tail. Bucket remainder steps: nibble residue
// sum, reciprocal quotient, remainder. Unused op codes skip to the hand-off.
// After reset the bucket head memory is cleared, one bucket head at a time, with req
// ready low. A new request is taken while the previous result waits on rsp.
// ----------------------------------------------------------------------------
module chained_hash_key_value_table #(
	parameter int NUM_BUCKETS = 16,
	parameter int POOL_SIZE   = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	chkv_req_if.sink         req,
	chkv_rsp_if.source       rsp
);
	import chkv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	chkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	chkv_dp #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.POOL_SIZE   (POOL_SIZE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_op      (req.op),
		.req_key     (req.key),
		.req_value   (req.value),
		.found       (rsp.found),
		.read_value  (rsp.read_value),
		.table_full  (rsp.table_full),
		.entry_total (rsp.entry_total)
	);
endmodule
